// File: rtl/fdmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmc_pkg
// Types and constants shared by the frame difference motion counter files.
// ----------------------------------------------------------------------------
package fdmc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int SAMPLES  = 6;
    localparam int PIX_W    = SAMPLE_W * SAMPLES;

    localparam int CNT_W    = 23;
    localparam int DIM_W    = 12;
    localparam int THR_W    = 8;
    localparam int MTH_W    = 14;

    localparam logic [CNT_W-1:0] COUNT_MAX    = 23'h7FFFFF;
    localparam int               MOTION_SCALE = 10000;

    // gray = (a + b + c) / 3 as (sum * 683) >> 11, exact for sums up to 765
    localparam logic [9:0] GRAY_RECIP = 10'd683;
    localparam int         GRAY_SHIFT = 11;

    localparam int RES_DEPTH = 16;
    localparam int RES_PTR_W = 4;
    localparam int RES_CNT_W = 5;

    // register reset values
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [THR_W-1:0] RST_PIXEL_THR    = 8'd25;
    localparam logic             RST_PER_CHANNEL  = 1'b0;
    localparam logic             RST_BLUR_ENABLE  = 1'b0;
    localparam logic             RST_COLOR_INPUT  = 1'b1;
    localparam logic [MTH_W-1:0] RST_MOTION_THR   = 14'd100;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_PIXEL_THR    = 3'd2,
        REG_PER_CHANNEL  = 3'd3,
        REG_BLUR_ENABLE  = 3'd4,
        REG_COLOR_INPUT  = 3'd5,
        REG_MOTION_THR   = 3'd6
    } reg_idx_t;

    // sample k at [8k+7:8k]: first r, g, b, then second r, g, b
    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [THR_W-1:0] pixel_threshold;
        logic             per_channel_mode;
        logic             blur_enable;
        logic             color_input;
        logic [MTH_W-1:0] motion_thr;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] changed;
    } res_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] changed_pixels;
        logic [CNT_W-1:0] total_pixels;
        logic             motion_detected;
    } res_item_t;

endpackage

// File: rtl/fdmc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmc_if
// Pixel pair and frame result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fdmc_pix_if;
    logic                          valid;
    logic                          ready;
    logic [fdmc_pkg::SAMPLE_W-1:0] first_red;
    logic [fdmc_pkg::SAMPLE_W-1:0] first_green;
    logic [fdmc_pkg::SAMPLE_W-1:0] first_blue;
    logic [fdmc_pkg::SAMPLE_W-1:0] second_red;
    logic [fdmc_pkg::SAMPLE_W-1:0] second_green;
    logic [fdmc_pkg::SAMPLE_W-1:0] second_blue;

    modport source (
        output valid, first_red, first_green, first_blue,
        output second_red, second_green, second_blue,
        input  ready
    );
    modport sink (
        input  valid, first_red, first_green, first_blue,
        input  second_red, second_green, second_blue,
        output ready
    );
endinterface

interface fdmc_res_if;
    logic                       valid;
    logic                       ready;
    logic [fdmc_pkg::CNT_W-1:0] changed_pixels;
    logic [fdmc_pkg::CNT_W-1:0] total_pixels;
    logic                       motion_detected;

    modport source (
        output valid, changed_pixels, total_pixels, motion_detected,
        input  ready
    );
    modport sink (
        input  valid, changed_pixels, total_pixels, motion_detected,
        output ready
    );
endinterface

// File: rtl/frame_difference_motion_counter.sv
`timescale 1ns / 1ps
// Throughput: one pixel pair per cycle while pix_in.ready is high, sustained across rows and frames.
// After its last pixel pair is accepted, a frame result passes through the row store read,
// window, blur, judge, count, two multiply stages and result queue before it is valid.
// Up to 16 frame results may be outstanding; pix_in.ready drops only at that point.
// Reset (rst_n low, asynchronous) restores register defaults and clears positions,
// window and counts; the row stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// frame_difference_motion_counter
// Counts pixels that differ between two frames, optionally after a 3x3 blur,
// and reports changed count, total count and a motion flag per frame.
// ----------------------------------------------------------------------------
module frame_difference_motion_counter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fdmc_pix_if.sink    pix_in,
    fdmc_res_if.source  res_out
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = CW + 1;
    localparam int HW = RW + 1;
    localparam int FWX = (WW > fdmc_pkg::DIM_W) ? WW : fdmc_pkg::DIM_W;
    localparam int FHX = (HW > fdmc_pkg::DIM_W) ? HW : fdmc_pkg::DIM_W;

    // configuration
    fdmc_pkg::cfg_t     cfg_reg;
    fdmc_pkg::reg_idx_t reg_idx;
    logic               cfg_wr;
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;

    // raster position
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic [WW-1:0]      col_p1;
    logic [WW:0]        col_p2;
    logic [HW-1:0]      row_p1;
    logic [HW:0]        row_p2;
    logic               row_end;
    logic               frame_end;
    logic               blur_on;
    logic               raw_judge;
    logic               blur_judge;

    logic               acc;
    fdmc_pkg::pix_t     cur_pix;
    logic               space;

    // row stores
    fdmc_pkg::pix_t     older_mem [MAX_WIDTH];
    fdmc_pkg::pix_t     newer_mem [MAX_WIDTH];
    fdmc_pkg::pix_t     rd_older_reg;
    fdmc_pkg::pix_t     rd_newer_reg;
    fdmc_pkg::pix_t     fwd_older_reg;
    fdmc_pkg::pix_t     fwd_newer_reg;
    logic               fwd_hit_reg;
    fdmc_pkg::pix_t     older_eff;
    fdmc_pkg::pix_t     newer_eff;

    // stage 1: row store data
    logic               s1_valid_reg;
    fdmc_pkg::pix_t     s1_cur_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               s1_raw_reg;
    logic               s1_blur_reg;
    logic               s1_end_reg;

    // blur window, [row][col], col 2 newest, row 2 current
    fdmc_pkg::pix_t [2:0][2:0] win_reg;

    // stage 2: blur
    logic               s2_valid_reg;
    fdmc_pkg::pix_t     s2_cur_reg;
    logic               s2_raw_reg;
    logic               s2_blur_reg;
    logic               s2_end_reg;
    fdmc_pkg::pix_t     blur_pix;

    // stage 3: judge
    logic               s3_valid_reg;
    fdmc_pkg::pix_t     s3_cur_reg;
    fdmc_pkg::pix_t     s3_bpix_reg;
    logic               s3_raw_reg;
    logic               s3_blur_reg;
    logic               s3_end_reg;
    logic               raw_chg;
    logic               blur_chg;

    // stage 4: count
    logic               s4_valid_reg;
    logic [1:0]         s4_inc_reg;
    logic               s4_end_reg;
    logic [fdmc_pkg::CNT_W-1:0] count_reg;
    logic [fdmc_pkg::CNT_W-1:0] count_sat;
    logic [fdmc_pkg::CNT_W:0]   count_sum;
    fdmc_pkg::res_req_t rq_reg;

    function automatic logic [fdmc_pkg::SAMPLE_W-1:0] abs_diff(
        input logic [fdmc_pkg::SAMPLE_W-1:0] a,
        input logic [fdmc_pkg::SAMPLE_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [fdmc_pkg::SAMPLE_W-1:0] gray(
        input logic [fdmc_pkg::SAMPLE_W-1:0] r,
        input logic [fdmc_pkg::SAMPLE_W-1:0] g,
        input logic [fdmc_pkg::SAMPLE_W-1:0] b
    );
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = 10'(r) + 10'(g) + 10'(b);
        prod = 20'(sum) * 20'(fdmc_pkg::GRAY_RECIP);
        return prod[fdmc_pkg::GRAY_SHIFT +: fdmc_pkg::SAMPLE_W];
    endfunction

    function automatic logic pix_changed(
        input fdmc_pkg::pix_t                 s,
        input logic [fdmc_pkg::THR_W-1:0]     thr,
        input logic                           color,
        input logic                           per_ch
    );
        logic res;
        res = 1'b0;
        if (!color)
        begin
            res = abs_diff(s[7:0], s[31:24]) > thr;
        end
        else if (!per_ch)
        begin
            res = abs_diff(gray(s[7:0], s[15:8], s[23:16]),
                           gray(s[31:24], s[39:32], s[47:40])) > thr;
        end
        else
        begin
            res = (abs_diff(s[7:0],   s[31:24]) > thr) ||
                  (abs_diff(s[15:8],  s[39:32]) > thr) ||
                  (abs_diff(s[23:16], s[47:40]) > thr);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- config port
    assign pready  = 1'b1;
    assign reg_idx = fdmc_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width      <= fdmc_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height     <= fdmc_pkg::RST_FRAME_HEIGHT;
            cfg_reg.pixel_threshold  <= fdmc_pkg::RST_PIXEL_THR;
            cfg_reg.per_channel_mode <= fdmc_pkg::RST_PER_CHANNEL;
            cfg_reg.blur_enable      <= fdmc_pkg::RST_BLUR_ENABLE;
            cfg_reg.color_input      <= fdmc_pkg::RST_COLOR_INPUT;
            cfg_reg.motion_thr       <= fdmc_pkg::RST_MOTION_THR;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                fdmc_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= pwdata[fdmc_pkg::DIM_W-1:0];
                fdmc_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= pwdata[fdmc_pkg::DIM_W-1:0];
                fdmc_pkg::REG_PIXEL_THR:
                    cfg_reg.pixel_threshold <= pwdata[fdmc_pkg::THR_W-1:0];
                fdmc_pkg::REG_PER_CHANNEL:
                    cfg_reg.per_channel_mode <= pwdata[0];
                fdmc_pkg::REG_BLUR_ENABLE:
                    cfg_reg.blur_enable <= pwdata[0];
                fdmc_pkg::REG_COLOR_INPUT:
                    cfg_reg.color_input <= pwdata[0];
                fdmc_pkg::REG_MOTION_THR:
                    cfg_reg.motion_thr <= pwdata[fdmc_pkg::MTH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            fdmc_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            fdmc_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            fdmc_pkg::REG_PIXEL_THR:    prdata = 32'(cfg_reg.pixel_threshold);
            fdmc_pkg::REG_PER_CHANNEL:  prdata = 32'(cfg_reg.per_channel_mode);
            fdmc_pkg::REG_BLUR_ENABLE:  prdata = 32'(cfg_reg.blur_enable);
            fdmc_pkg::REG_COLOR_INPUT:  prdata = 32'(cfg_reg.color_input);
            fdmc_pkg::REG_MOTION_THR:   prdata = 32'(cfg_reg.motion_thr);
            default:                    prdata = '0;
        endcase
    end

    // zero acts as one, oversize saturates
    always_comb
    begin
        if (cfg_reg.frame_width == '0)
            w_eff = WW'(1);
        else if (FWX'(cfg_reg.frame_width) > FWX'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg_reg.frame_width);

        if (cfg_reg.frame_height == '0)
            h_eff = HW'(1);
        else if (FHX'(cfg_reg.frame_height) > FHX'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(cfg_reg.frame_height);
    end

    // ---------------------------------------------------------------- accept side
    assign pix_in.ready = space;
    assign acc          = pix_in.valid && space;
    assign cur_pix      = {pix_in.second_blue, pix_in.second_green, pix_in.second_red,
                           pix_in.first_blue, pix_in.first_green, pix_in.first_red};

    always_comb
    begin
        col_p1    = WW'(col_reg) + WW'(1);
        col_p2    = (WW + 1)'(col_reg) + (WW + 1)'(2);
        row_p1    = HW'(row_reg) + HW'(1);
        row_p2    = (HW + 1)'(row_reg) + (HW + 1)'(2);
        row_end   = col_p1 >= w_eff;
        frame_end = row_end && (row_p1 >= h_eff);
        col_next  = row_end ? '0 : col_p1[CW-1:0];
        if (!row_end)
            row_next = row_reg;
        else if (frame_end)
            row_next = '0;
        else
            row_next = row_p1[RW-1:0];

        blur_on    = cfg_reg.blur_enable && (w_eff >= WW'(3)) && (h_eff >= HW'(3));
        // interior pixels wait for their blurred value instead
        raw_judge  = !(blur_on && (row_reg != '0) && (row_p2 <= {1'b0, h_eff}) &&
                       (col_reg != '0) && (col_p2 <= {1'b0, w_eff}));
        // the pixel up and to the left is complete now
        blur_judge = blur_on && (row_reg >= RW'(2)) && (col_reg >= CW'(2)) &&
                     (row_p1 <= h_eff) && (col_p1 <= w_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------- row stores
    // the column being written this cycle reads stale data: take the forwarded copy
    assign older_eff = fwd_hit_reg ? fwd_older_reg : rd_older_reg;
    assign newer_eff = fwd_hit_reg ? fwd_newer_reg : rd_newer_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_older_reg <= older_mem[col_reg];
            rd_newer_reg <= newer_mem[col_reg];
        end
        if (s1_valid_reg)
        begin
            older_mem[s1_col_reg] <= newer_eff;
            newer_mem[s1_col_reg] <= s1_cur_reg;
        end
    end

    // ---------------------------------------------------------------- blur
    always_comb
    begin
        logic [11:0] bsum;
        blur_pix = '0;
        for (int k = 0; k < fdmc_pkg::SAMPLES; k++)
        begin
            bsum = 12'(win_reg[0][0][8*k +: 8])        + (12'(win_reg[0][1][8*k +: 8]) << 1) +
                   12'(win_reg[0][2][8*k +: 8])        + (12'(win_reg[1][0][8*k +: 8]) << 1) +
                   (12'(win_reg[1][1][8*k +: 8]) << 2) + (12'(win_reg[1][2][8*k +: 8]) << 1) +
                   12'(win_reg[2][0][8*k +: 8])        + (12'(win_reg[2][1][8*k +: 8]) << 1) +
                   12'(win_reg[2][2][8*k +: 8]);
            blur_pix[8*k +: 8] = bsum[11:4];
        end
    end

    // ---------------------------------------------------------------- judge and count
    always_comb
    begin
        raw_chg  = s3_raw_reg && pix_changed(s3_cur_reg, cfg_reg.pixel_threshold,
                                             cfg_reg.color_input, cfg_reg.per_channel_mode);
        blur_chg = s3_blur_reg && pix_changed(s3_bpix_reg, cfg_reg.pixel_threshold,
                                              cfg_reg.color_input, cfg_reg.per_channel_mode);
    end

    always_comb
    begin
        count_sum = (fdmc_pkg::CNT_W + 1)'(count_reg) + (fdmc_pkg::CNT_W + 1)'(s4_inc_reg);
        count_sat = count_sum[fdmc_pkg::CNT_W] ? fdmc_pkg::COUNT_MAX
                                               : count_sum[fdmc_pkg::CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            win_reg      <= '0;
            count_reg    <= '0;
            rq_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            rq_reg.valid <= s4_valid_reg && s4_end_reg;
            if (s1_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= older_eff;
                win_reg[1][2] <= newer_eff;
                win_reg[2][2] <= s1_cur_reg;
            end
            if (s4_valid_reg)
            begin
                if (s4_end_reg)
                begin
                    rq_reg.changed <= count_sat;
                    count_reg      <= '0;
                end
                else
                begin
                    count_reg <= count_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cur_reg  <= cur_pix;
            s1_col_reg  <= col_reg;
            s1_raw_reg  <= raw_judge;
            s1_blur_reg <= blur_judge;
            s1_end_reg  <= frame_end;
            fwd_hit_reg <= s1_valid_reg && (s1_col_reg == col_reg);
        end
        if (s1_valid_reg)
        begin
            fwd_older_reg <= newer_eff;
            fwd_newer_reg <= s1_cur_reg;
            s2_cur_reg    <= s1_cur_reg;
            s2_raw_reg    <= s1_raw_reg;
            s2_blur_reg   <= s1_blur_reg;
            s2_end_reg    <= s1_end_reg;
        end
        if (s2_valid_reg)
        begin
            s3_cur_reg  <= s2_cur_reg;
            s3_bpix_reg <= blur_pix;
            s3_raw_reg  <= s2_raw_reg;
            s3_blur_reg <= s2_blur_reg;
            s3_end_reg  <= s2_end_reg;
        end
        if (s3_valid_reg)
        begin
            s4_inc_reg <= 2'(raw_chg) + 2'(blur_chg);
            s4_end_reg <= s3_end_reg;
        end
    end

    // ---------------------------------------------------------------- frame results
    fdmc_result #(
        .WW (WW),
        .HW (HW)
    ) u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (rq_reg),
        .claim      (acc && frame_end),
        .w_eff      (w_eff),
        .h_eff      (h_eff),
        .motion_thr (cfg_reg.motion_thr),
        .space      (space),
        .res_out    (res_out)
    );

endmodule

// File: rtl/fdmc_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmc_result
// Frame result math (total, motion compare), result queue and output register.
// ----------------------------------------------------------------------------
module fdmc_result #(
    parameter int WW = 12,
    parameter int HW = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fdmc_pkg::res_req_t         req,
    input  logic                       claim,
    input  logic [WW-1:0]              w_eff,
    input  logic [HW-1:0]              h_eff,
    input  logic [fdmc_pkg::MTH_W-1:0] motion_thr,
    output logic                       space,
    fdmc_res_if.source                 res_out
);

    localparam int PW   = WW + HW;
    localparam int TOTW = (PW > fdmc_pkg::CNT_W) ? PW : fdmc_pkg::CNT_W;
    localparam int TPW  = fdmc_pkg::MTH_W + TOTW;
    localparam int CPW  = fdmc_pkg::CNT_W + fdmc_pkg::MTH_W;
    localparam int CMPW = (CPW > TPW) ? CPW : TPW;

    logic                          a_valid_reg;
    logic [fdmc_pkg::CNT_W-1:0]    a_changed_reg;
    logic [TOTW-1:0]               a_total_reg;
    logic [CPW-1:0]                a_chprod_reg;

    logic                          b_valid_reg;
    logic [fdmc_pkg::CNT_W-1:0]    b_changed_reg;
    logic [TOTW-1:0]               b_total_reg;
    logic [CPW-1:0]                b_chprod_reg;
    logic [TPW-1:0]                b_thrprod_reg;

    fdmc_pkg::res_item_t           fifo_mem [fdmc_pkg::RES_DEPTH];
    logic [fdmc_pkg::RES_PTR_W-1:0] wr_ptr_reg;
    logic [fdmc_pkg::RES_PTR_W-1:0] rd_ptr_reg;
    logic [fdmc_pkg::RES_CNT_W-1:0] fifo_cnt_reg;
    logic [fdmc_pkg::RES_CNT_W-1:0] fifo_cnt_next;
    logic [fdmc_pkg::RES_CNT_W-1:0] pending_reg;
    logic [fdmc_pkg::RES_CNT_W-1:0] pending_next;

    logic                          out_valid_reg;
    fdmc_pkg::res_item_t           out_item_reg;

    fdmc_pkg::res_item_t           push_item;
    logic                          load;
    logic                          pop;

    always_comb
    begin
        push_item.changed_pixels  = b_changed_reg;
        push_item.total_pixels    = b_total_reg[fdmc_pkg::CNT_W-1:0];
        push_item.motion_detected = CMPW'(b_chprod_reg) >= CMPW'(b_thrprod_reg);
    end

    assign pop  = out_valid_reg && res_out.ready;
    assign load = (fifo_cnt_reg != '0) && (!out_valid_reg || res_out.ready);

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg + fdmc_pkg::RES_CNT_W'(b_valid_reg)
                        - fdmc_pkg::RES_CNT_W'(load);
        pending_next  = pending_reg + fdmc_pkg::RES_CNT_W'(claim)
                        - fdmc_pkg::RES_CNT_W'(pop);
    end

    // every claimed frame holds a slot from accept until its transaction completes
    assign space = pending_reg != fdmc_pkg::RES_CNT_W'(fdmc_pkg::RES_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fifo_cnt_reg  <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg  <= req.valid;
            b_valid_reg  <= a_valid_reg;
            fifo_cnt_reg <= fifo_cnt_next;
            pending_reg  <= pending_next;
            if (b_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (load)
            begin
                rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            a_changed_reg <= req.changed;
            a_total_reg   <= TOTW'(w_eff) * TOTW'(h_eff);
            a_chprod_reg  <= CPW'(req.changed) * CPW'(fdmc_pkg::MOTION_SCALE);
        end
        if (a_valid_reg)
        begin
            b_changed_reg <= a_changed_reg;
            b_total_reg   <= a_total_reg;
            b_chprod_reg  <= a_chprod_reg;
            b_thrprod_reg <= TPW'(motion_thr) * TPW'(a_total_reg);
        end
        if (b_valid_reg)
        begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
        if (load)
        begin
            out_item_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    assign res_out.valid           = out_valid_reg;
    assign res_out.changed_pixels  = out_item_reg.changed_pixels;
    assign res_out.total_pixels    = out_item_reg.total_pixels;
    assign res_out.motion_detected = out_item_reg.motion_detected;

endmodule

// File: rtl/fdmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmc_checker
// Port-level checks for the frame difference motion counter, bound to the top.
// ----------------------------------------------------------------------------
module fdmc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [4:0]                 paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [fdmc_pkg::CNT_W-1:0] out_changed,
    input logic [fdmc_pkg::CNT_W-1:0] out_total,
    input logic                       out_motion
);

    logic                       apb_wr;
    logic [31:0]                wr_masked;
    logic [fdmc_pkg::MTH_W-1:0] thr_reg;

    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        logic [31:0] m;
        case (fdmc_pkg::reg_idx_t'(idx))
            fdmc_pkg::REG_FRAME_WIDTH:  m = 32'h0000_0FFF;
            fdmc_pkg::REG_FRAME_HEIGHT: m = 32'h0000_0FFF;
            fdmc_pkg::REG_PIXEL_THR:    m = 32'h0000_00FF;
            fdmc_pkg::REG_PER_CHANNEL:  m = 32'h0000_0001;
            fdmc_pkg::REG_BLUR_ENABLE:  m = 32'h0000_0001;
            fdmc_pkg::REG_COLOR_INPUT:  m = 32'h0000_0001;
            fdmc_pkg::REG_MOTION_THR:   m = 32'h0000_3FFF;
            default:                    m = '0;
        endcase
        return m;
    endfunction

    assign apb_wr    = psel && penable && pwrite && pready;
    assign wr_masked = pwdata & reg_mask(paddr[4:2]);

    // shadow of the motion threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= fdmc_pkg::RST_MOTION_THR;
        else if (apb_wr && (fdmc_pkg::reg_idx_t'(paddr[4:2]) == fdmc_pkg::REG_MOTION_THR))
            thr_reg <= pwdata[fdmc_pkg::MTH_W-1:0];
    end

    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        apb_wr |=> (paddr != $past(paddr)) || (prdata == $past(wr_masked)))
        else $error("register readback differs from written value");

    a_no_motion_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_changed == '0) && (thr_reg != '0)) |-> !out_motion)
        else $error("motion flagged with no changed pixels and nonzero threshold");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(out_changed) && $stable(out_total) && $stable(out_motion)))
        else $error("result payload changed while stalled");

endmodule

bind frame_difference_motion_counter fdmc_checker u_fdmc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .out_valid   (res_out.valid),
    .out_ready   (res_out.ready),
    .out_changed (res_out.changed_pixels),
    .out_total   (res_out.total_pixels),
    .out_motion  (res_out.motion_detected)
);
